/* rtl/kpds_pkg.sv */
package kpds_pkg;

   localparam int NUM_KEYS_DEFAULT = 4;

   localparam int PIN_W   = 16;
   localparam int IDX_W   = 2;
   localparam int KIND_W  = 3;
   localparam int CODE_W  = 3;
   localparam int HOLD_W  = 32;
   localparam int CFG_W   = 16;
   localparam int APB_AW  = 3;
   localparam int APB_DW  = 32;

   localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SCAN      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_READ      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SKIP      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLR_TIMER = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CLR_EVENT = 3'd5;

   // register indexes (byte address 4*i)
   localparam logic REG_MIN_HOLD    = 1'b0;
   localparam logic REG_SKIP_WINDOW = 1'b1;

   // decoded operation, already gated by the stage advance
   typedef struct packed {
      logic tick;
      logic scan;
      logic read;
      logic skip;       // key index in range
      logic clr_timer;  // key index in range
      logic clr_event;
   } op_type;

   // winning release of one scan
   typedef struct packed {
      logic              hit;
      logic [CODE_W-1:0] code;
      logic [HOLD_W-1:0] hold;
   } release_type;

endpackage

/* rtl/kpds_key_bank.sv */
module kpds_key_bank #(
   parameter int NUM_KEYS = kpds_pkg::NUM_KEYS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kpds_pkg::op_type              op,
   input  logic [kpds_pkg::PIN_W-1:0]    pins,
   input  logic [kpds_pkg::IDX_W-1:0]    idx,
   input  logic [kpds_pkg::CFG_W-1:0]    min_hold,
   output kpds_pkg::release_type         rel,
   output logic [kpds_pkg::HOLD_W-1:0]   hold_timer
);
   import kpds_pkg::*;

   logic [NUM_KEYS-1:0] held_ff, held_in;
   logic [NUM_KEYS-1:0] blocked_ff, blocked_in;
   logic [HOLD_W-1:0]   cnt_ff [NUM_KEYS];
   logic [HOLD_W-1:0]   cnt_in [NUM_KEYS];

   always_comb begin
      held_in    = held_ff;
      blocked_in = blocked_ff;
      rel        = '0;
      hold_timer = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         cnt_in[k] = cnt_ff[k];
         if (op.tick) begin
            if (held_ff[k] && cnt_ff[k] != HOLD_MAX) begin
               cnt_in[k] = cnt_ff[k] + HOLD_W'(1);
            end
         end
         if (op.scan) begin
            if (!pins[k]) begin
               if (!blocked_ff[k]) begin
                  held_in[k] = 1'b1;
               end
            end else begin
               blocked_in[k] = 1'b0;
               held_in[k]    = 1'b0;
               cnt_in[k]     = '0;
               // later keys overwrite, so the highest one wins
               if (held_ff[k] && cnt_ff[k] > HOLD_W'(min_hold)) begin
                  rel.hit  = 1'b1;
                  rel.code = CODE_W'(k + 1);
                  rel.hold = cnt_ff[k];
               end
            end
         end
         if (32'(idx) == k) begin
            if (op.skip) begin
               held_in[k]    = 1'b0;
               blocked_in[k] = 1'b1;
               cnt_in[k]     = '0;
            end
            if (op.clr_timer) begin
               cnt_in[k] = '0;
            end
         end
      end
      // readout of the addressed key after this request
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (32'(idx) == k) begin
            hold_timer = cnt_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         blocked_ff <= '0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         held_ff    <= held_in;
         blocked_ff <= blocked_in;
         for (int k = 0; k < NUM_KEYS; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
      end
   end

endmodule

/* rtl/kpds_event.sv */
module kpds_event (
   input  logic                          clock,
   input  logic                          reset,
   input  kpds_pkg::op_type              op,
   input  kpds_pkg::release_type         rel,
   input  logic [kpds_pkg::CFG_W-1:0]    skip_window,
   output logic [kpds_pkg::CODE_W-1:0]   event_code,
   output logic [kpds_pkg::HOLD_W-1:0]   event_hold
);
   import kpds_pkg::*;

   logic [CODE_W-1:0] code_ff, code_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic [CFG_W-1:0]  skip_ff, skip_in;

   always_comb begin
      code_in    = code_ff;
      hold_in    = hold_ff;
      skip_in    = skip_ff;
      event_code = '0;
      event_hold = '0;
      if (op.tick && skip_ff != '0) begin
         skip_in = skip_ff - CFG_W'(1);
      end
      if (op.scan) begin
         if (rel.hit) begin
            code_in = rel.code;
            hold_in = rel.hold;
         end
         // events are dropped while the skip window runs
         if (skip_ff != '0) begin
            code_in = '0;
         end
      end
      if (op.read) begin
         event_code = code_ff;
         if (code_ff != '0) begin
            event_hold = hold_ff;
         end
         code_in = '0;
      end
      if (op.skip) begin
         skip_in = skip_window;
      end
      if (op.clr_event) begin
         code_in = '0;
         hold_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= '0;
         hold_ff <= '0;
         skip_ff <= '0;
      end else begin
         code_ff <= code_in;
         hold_ff <= hold_in;
         skip_ff <= skip_in;
      end
   end

endmodule

/* rtl/key_press_duration_scanner.sv */
// Key press duration scanner. Watches NUM_KEYS active-low keys (key k on pin
// bit k) and times how long each is held, in tick requests. Every request
// (tick, scan, read event, skip key, clear timer, clear event) gives exactly
// one response carrying the consumed event code and hold time (zero unless
// the request is a read) plus the hold timer of req_key_index after the
// request. Accepts one request per clock while responses are taken; the
// request is captured in the input register, and when the response slot is
// free or drains the whole state update runs in one combinational pass into
// the response register. A stalled response does not stop intake while the
// input register is free. min_hold_ms (address 0) and skip_window_ms
// (address 4) must be written over the APB port only while the block is idle;
// the block itself does not enforce this. They read back zero-extended.
module key_press_duration_scanner #(
   parameter int NUM_KEYS = kpds_pkg::NUM_KEYS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kpds_pkg::KIND_W-1:0]   req_kind,
   input  logic [kpds_pkg::PIN_W-1:0]    req_pin_sample,
   input  logic [kpds_pkg::IDX_W-1:0]    req_key_index,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kpds_pkg::CODE_W-1:0]   rsp_event_code,
   output logic [kpds_pkg::HOLD_W-1:0]   rsp_event_hold_ms,
   output logic [kpds_pkg::HOLD_W-1:0]   rsp_hold_timer,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [kpds_pkg::APB_AW-1:0]   csr_paddr,
   input  logic [kpds_pkg::APB_DW-1:0]   csr_pwdata,
   output logic [kpds_pkg::APB_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import kpds_pkg::*;

   // --- config registers ---
   logic [CFG_W-1:0] min_hold_ff, min_hold_in;
   logic [CFG_W-1:0] skip_window_ff, skip_window_in;
   logic             csr_wr;
   logic             csr_sel;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_paddr[2];

   always_comb begin
      min_hold_in    = min_hold_ff;
      skip_window_in = skip_window_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            REG_MIN_HOLD:    min_hold_in    = csr_pwdata[CFG_W-1:0];
            REG_SKIP_WINDOW: skip_window_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
      unique case (csr_sel)
         REG_MIN_HOLD:    csr_prdata = APB_DW'(min_hold_ff);
         REG_SKIP_WINDOW: csr_prdata = APB_DW'(skip_window_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_hold_ff    <= CFG_W'(50);
         skip_window_ff <= CFG_W'(100);
      end else begin
         min_hold_ff    <= min_hold_in;
         skip_window_ff <= skip_window_in;
      end
   end

   // --- input register ---
   logic              in_valid_ff, in_valid_in;
   logic [KIND_W-1:0] in_kind_ff;
   logic [PIN_W-1:0]  in_pins_ff;
   logic [IDX_W-1:0]  in_idx_ff;
   logic              advance;   // request in the input register is processed
   logic              req_take;

   // the input register moves on whenever the response slot is free or drains
   assign advance   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_kind;
         in_pins_ff <= req_pin_sample;
         in_idx_ff  <= req_key_index;
      end
   end

   // --- decode; out-of-range key index turns skip and clear timer into no-ops ---
   op_type op;
   logic   idx_ok;

   assign idx_ok = 32'(in_idx_ff) < NUM_KEYS;

   always_comb begin
      op = '0;
      if (advance) begin
         unique case (in_kind_ff)
            KIND_TICK:      op.tick      = 1'b1;
            KIND_SCAN:      op.scan      = 1'b1;
            KIND_READ:      op.read      = 1'b1;
            KIND_SKIP:      op.skip      = idx_ok;
            KIND_CLR_TIMER: op.clr_timer = idx_ok;
            KIND_CLR_EVENT: op.clr_event = 1'b1;
            default: ;  // unused kinds change nothing
         endcase
      end
   end

   // --- per-key state and pending event ---
   release_type       rel;
   logic [HOLD_W-1:0] timer_next;
   logic [CODE_W-1:0] code_next;
   logic [HOLD_W-1:0] hold_next;

   kpds_key_bank #(
      .NUM_KEYS (NUM_KEYS)
   ) u_keys (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .pins       (in_pins_ff),
      .idx        (in_idx_ff),
      .min_hold   (min_hold_ff),
      .rel        (rel),
      .hold_timer (timer_next)
   );

   kpds_event u_event (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .rel         (rel),
      .skip_window (skip_window_ff),
      .event_code  (code_next),
      .event_hold  (hold_next)
   );

   // --- response register ---
   logic rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_event_code    <= code_next;
         rsp_event_hold_ms <= hold_next;
         rsp_hold_timer    <= idx_ok ? timer_next : '0;
      end
   end

endmodule

/* rtl/kpds_checker.sv */
module kpds_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [kpds_pkg::CODE_W-1:0]   rsp_event_code,
   input logic [kpds_pkg::HOLD_W-1:0]   rsp_event_hold_ms,
   input logic [kpds_pkg::HOLD_W-1:0]   rsp_hold_timer
);
   import kpds_pkg::*;

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code)
         && $stable(rsp_event_hold_ms) && $stable(rsp_hold_timer))
      else $error("response changed while stalled");

   // no event, no hold time
   a_code_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == '0 |-> rsp_event_hold_ms == '0)
      else $error("hold time without event code");

   // reset empties the response slot
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // with the response slot empty, intake never stalls
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response slot");

endmodule

bind key_press_duration_scanner kpds_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_event_code    (rsp_event_code),
   .rsp_event_hold_ms (rsp_event_hold_ms),
   .rsp_hold_timer    (rsp_hold_timer)
);

/* test/key_press_duration_scanner_test.sv */
`timescale 1ns / 1ps

module key_press_duration_scanner_test;
   import kpds_pkg::*;

   localparam int KEYS = NUM_KEYS_DEFAULT;

   // kinds 6 and 7 have no meaning; the block must treat them as no-ops
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   // one response as the block should return it
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [HOLD_W-1:0] event_hold;
      logic [HOLD_W-1:0] timer;
   } key_report_type;

   // Behavior model plus in-order response check.
   class key_event_board;
      logic [CFG_W-1:0]  min_hold;
      logic [CFG_W-1:0]  skip_window;
      bit                held[KEYS];
      bit                blocked[KEYS];
      logic [HOLD_W-1:0] hold_ticks[KEYS];
      logic [CODE_W-1:0] pend_code;
      logic [HOLD_W-1:0] pend_hold;
      logic [CFG_W-1:0]  skip_left;
      key_report_type    expected_q[$];
      int                errors;

      function new();
         min_hold = 16'd50;
         skip_window = 16'd100;
         for (int k = 0; k < KEYS; k++) begin
            held[k] = 1'b0;
            blocked[k] = 1'b0;
            hold_ticks[k] = '0;
         end
         pend_code = '0;
         pend_hold = '0;
         skip_left = '0;
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // apply one accepted request to the model and queue its response
      function void note_request(input logic [KIND_W-1:0] kind,
                                 input logic [PIN_W-1:0] pins,
                                 input logic [IDX_W-1:0] idx);
         key_report_type r;
         bit             idx_ok;
         idx_ok = int'(idx) < KEYS;
         r = '0;
         case (kind)
            KIND_TICK: begin
               for (int k = 0; k < KEYS; k++)
                  if (held[k] && hold_ticks[k] != HOLD_MAX)
                     hold_ticks[k] = hold_ticks[k] + HOLD_W'(1);
               if (skip_left != 0)
                  skip_left = skip_left - CFG_W'(1);
            end
            KIND_SCAN: begin
               // walk keys upward so the highest released key wins
               for (int k = 0; k < KEYS && k < PIN_W; k++) begin
                  if (!pins[k]) begin
                     if (!blocked[k])
                        held[k] = 1'b1;
                  end else begin
                     blocked[k] = 1'b0;
                     if (held[k]) begin
                        held[k] = 1'b0;
                        if (hold_ticks[k] > HOLD_W'(min_hold)) begin
                           pend_code = CODE_W'(k + 1);
                           pend_hold = hold_ticks[k];
                        end
                     end
                     hold_ticks[k] = '0;
                  end
               end
               // skip window swallows the event, hold value stays
               if (pend_code != 0 && skip_left != 0)
                  pend_code = '0;
            end
            KIND_READ: begin
               r.code = pend_code;
               if (pend_code != 0)
                  r.event_hold = pend_hold;
               pend_code = '0;
            end
            KIND_SKIP: begin
               if (idx_ok) begin
                  held[idx] = 1'b0;
                  hold_ticks[idx] = '0;
                  blocked[idx] = 1'b1;
                  skip_left = skip_window;
               end
            end
            KIND_CLR_TIMER: begin
               if (idx_ok)
                  hold_ticks[idx] = '0;
            end
            KIND_CLR_EVENT: begin
               pend_code = '0;
               pend_hold = '0;
            end
            default: ;
         endcase
         r.timer = idx_ok ? hold_ticks[idx] : '0;
         expected_q.push_back(r);
      endfunction

      task report_mismatch(input string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_response(input logic [CODE_W-1:0] code,
                          input logic [HOLD_W-1:0] event_hold,
                          input logic [HOLD_W-1:0] timer);
         key_report_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("response with no request outstanding, code %0d",
                                      code));
            return;
         end
         want = expected_q.pop_front();
         if (code !== want.code)
            report_mismatch($sformatf("event_code %0d, expected %0d", code, want.code));
         if (event_hold !== want.event_hold)
            report_mismatch($sformatf("event_hold_ms %0d, expected %0d",
                                      event_hold, want.event_hold));
         if (timer !== want.timer)
            report_mismatch($sformatf("hold_timer %0d, expected %0d", timer, want.timer));
      endtask
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind = KIND_TICK;
   logic [PIN_W-1:0]    req_pin_sample = '1;
   logic [IDX_W-1:0]    req_key_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [CODE_W-1:0]   rsp_event_code;
   logic [HOLD_W-1:0]   rsp_event_hold_ms;
   logic [HOLD_W-1:0]   rsp_hold_timer;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [APB_AW-1:0]   csr_paddr = '0;
   logic [APB_DW-1:0]   csr_pwdata = '0;
   logic [APB_DW-1:0]   csr_prdata;
   logic                csr_pready;

   key_event_board board = new();

   // idle_pct: chance of a gap before each request (and of a response stall)
   // calm: set for the tail of the run, no gaps or stalls at all
   int   idle_pct = 15;
   bit   calm = 1'b0;
   // keys the random stimulus currently holds down (active high here)
   logic [KEYS-1:0] keys_down = '0;

   key_press_duration_scanner #(.NUM_KEYS(KEYS)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_pin_sample    (req_pin_sample),
      .req_key_index     (req_key_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_code    (rsp_event_code),
      .rsp_event_hold_ms (rsp_event_hold_ms),
      .rsp_hold_timer    (rsp_hold_timer),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog, far above the slowest legal run (~2000 requests with full
   // gaps and stalls stays well under 0.5 ms).
   initial begin
      #(5_000_000);
      $display("key_press_duration_scanner regression: fail");
      $finish;
   end

   // Response side: random stall bursts, none when calm.
   initial begin
      forever begin
         @(posedge clock);
         if (calm || $urandom_range(0, 99) >= idle_pct) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Handshake values are read right after the edge, before any update of
   // that edge lands, so they are the values the block saw.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         board.check_response(rsp_event_code, rsp_event_hold_ms, rsp_hold_timer);
   end

   // Drive one request; returns in the time step of its acceptance edge.
   // valid is only lowered when a gap is taken, so it never drops and rises
   // in the same step.
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [PIN_W-1:0] pins,
                               input logic [IDX_W-1:0] idx);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_pin_sample <= pins;
      req_key_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(kind, pins, idx);
   endtask

   // APB write: setup then access; upper data bits are noise the block drops
   task automatic csr_write(input logic reg_idx, input logic [CFG_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (reg_idx == REG_MIN_HOLD)
         board.min_hold = value;
      else
         board.skip_window = value;
   endtask

   // Drain the pipe, then load both thresholds.
   task automatic set_thresholds(input logic [CFG_W-1:0] min_hold,
                                 input logic [CFG_W-1:0] window);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      // every request answers, so the pipe is empty once all responses are in
      repeat (4) @(posedge clock);
      csr_write(REG_MIN_HOLD, min_hold);
      csr_write(REG_SKIP_WINDOW, window);
   endtask

   // Random traffic. Scans mostly press or release one key at a time so that
   // holds build up across ticks; one scan in ten is raw pin noise.
   task automatic run_random(input int count, input int tick_pct);
      logic [KIND_W-1:0] kind;
      logic [PIN_W-1:0]  pins;
      int                pick;
      int                key;
      for (int i = 0; i < count; i++) begin
         pins = 16'($urandom);
         if ($urandom_range(0, 99) < tick_pct) begin
            kind = KIND_TICK;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               kind = KIND_SCAN;
               if ($urandom_range(0, 9) != 0) begin
                  if ($urandom_range(0, 9) < 7) begin
                     key = $urandom_range(0, KEYS - 1);
                     keys_down[key] = ~keys_down[key];
                  end
                  pins = {12'($urandom), ~keys_down};
               end
            end else if (pick < 70) kind = KIND_READ;
            else if (pick < 78) kind = KIND_SKIP;
            else if (pick < 86) kind = KIND_CLR_TIMER;
            else if (pick < 94) kind = KIND_CLR_EVENT;
            else kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
         end
         send_request(kind, pins, IDX_W'($urandom));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: any hold counts, short skip window.
      set_thresholds(16'd0, 16'd2);
      send_request(KIND_READ, 16'hFFFF, 2'd3);       // no event yet
      send_request(KIND_SCAN, 16'h0000, 2'd0);       // press every key
      send_request(KIND_TICK, 16'h0000, 2'd1);
      send_request(KIND_CLR_TIMER, 16'hFFFF, 2'd1);  // key 1 back to zero
      send_request(KIND_SCAN, 16'hFFFF, 2'd2);       // release all, key 3 wins
      send_request(KIND_READ, 16'h0000, 2'd0);       // consume it
      send_request(KIND_SCAN, 16'hFFF0, 2'd3);
      send_request(KIND_TICK, 16'h1234, 2'd2);
      send_request(KIND_SKIP, 16'hFFFF, 2'd2);       // block key 2, open window
      send_request(KIND_SCAN, 16'hFFFB, 2'd2);       // release event swallowed
      send_request(KIND_READ, 16'hFFFF, 2'd1);
      send_request(KIND_TICK, 16'h0000, 2'd0);       // window counts out...
      send_request(KIND_TICK, 16'h0000, 2'd0);
      send_request(KIND_TICK, 16'h0000, 2'd0);       // ...and stays at zero
      send_request(KIND_SCAN, 16'h0000, 2'd2);       // key 2 still blocked
      send_request(KIND_TICK, 16'hFFFF, 2'd3);
      send_request(KIND_SCAN, 16'hFFFF, 2'd2);       // release unblocks key 2
      send_request(KIND_CLR_EVENT, 16'h0000, 2'd0);
      send_request(KIND_READ, 16'hFFFF, 2'd3);       // nothing left to read
      send_request(KIND_SPARE_LO, 16'h8000, 2'd1);
      send_request(KIND_SPARE_HI, 16'h7FFF, 2'd3);
      send_request(KIND_SCAN, 16'hAAAA, 2'd0);       // keys 0 and 2 down
      send_request(KIND_TICK, 16'h5555, 2'd2);
      send_request(KIND_SCAN, 16'h5555, 2'd1);       // key 2 beats key 0
      send_request(KIND_READ, 16'h0000, 2'd2);

      // Random phases over several threshold settings.
      idle_pct = 15;
      set_thresholds(16'd5, 16'd20);
      run_random(300, 40);

      idle_pct = 0;                                  // a stretch with no gaps
      set_thresholds(16'd0, 16'd0);
      run_random(250, 35);

      idle_pct = 20;
      set_thresholds(16'hFFFF, 16'hFFFF);            // upper extremes
      run_random(250, 40);

      idle_pct = 15;
      set_thresholds(16'd50, 16'd100);               // power-on values
      run_random(250, 85);

      set_thresholds(16'($urandom_range(0, 12)), 16'($urandom_range(0, 40)));
      run_random(300, 45);

      set_thresholds(16'd3, 16'd1);
      run_random(200, 45);
      calm = 1'b1;                                   // tail at full rate
      run_random(150, 45);

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.errors == 0)
         $display("key_press_duration_scanner regression: pass");
      else
         $display("key_press_duration_scanner regression: fail");
      $finish;
   end

endmodule

/* files.f */
rtl/kpds_pkg.sv
rtl/kpds_key_bank.sv
rtl/kpds_event.sv
rtl/key_press_duration_scanner.sv
rtl/kpds_checker.sv
test/key_press_duration_scanner_test.sv
